>>> rtl/core/nwt_pkg.sv
// ----------------------------------------------------------------------------
// nwt_pkg: shared constants and helpers for the n-hit window trigger
// bin width, spread, defaults, opcodes, result status codes and register map
// ----------------------------------------------------------------------------
package nwt_pkg;

  localparam int BIN_NS       = 25;
  localparam int SPREAD       = 3;
  localparam int CHANNELS_DEF = 256;
  localparam int COLUMNS_DEF  = 1024;
  localparam int REM_W        = $clog2(BIN_NS);
  localparam int SLICE        = 16;
  localparam int SLICE_CNT_W  = $clog2(SLICE + 1);
  localparam int TIME_W       = 48;

  localparam logic [8:0]  THRESHOLD_RST = 9'd10;
  localparam logic [15:0] WINDOW_RST    = 16'd250;

  // item opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT_STORED  = 3'd0;
  localparam logic [2:0] ST_HIT_DROPPED = 3'd1;
  localparam logic [2:0] ST_WINDOW      = 3'd2;
  localparam logic [2:0] ST_SEARCH_DONE = 3'd3;
  localparam logic [2:0] ST_START_TAKEN = 3'd4;

  // configuration register indexes
  localparam logic REG_HIT_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW_NS     = 1'b1;

  function automatic logic [SLICE_CNT_W-1:0] popcount(input logic [SLICE-1:0] v);
    logic [SLICE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLICE; i++) begin
      n = n + SLICE_CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/nhit_window_trigger.sv
// ----------------------------------------------------------------------------
// nhit_window_trigger: n-hit multiplicity trigger over detector channels
// marks hits in a channel-by-bin table and searches it for busy bins
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low; opcode selects a
//   start-time candidate, a hit or a search. every item gives one result,
//   shown for one cycle with done high; the receiver cannot stall, so
//   results are never held back or lost.
// sequence per item
//   start candidate, dropped hit, unknown opcode: result registered at accept
//   stored hit: one pass through the divider by 25, then one read/write
//     pair of the table per marked bin
//   search: one pass through the divider, then for each column visited a
//     check, a table read, 16 channels counted per cycle and a compare
//   search that runs off the table: result, then a clearing pass, one
//     table row per cycle, with busy high
// reset
//   frame start goes to all ones, cursor to zero and the table is swept
//   clear row by row; busy stays high meanwhile. configuration
//   writes on cfg_we are taken at any time but belong to idle periods.
// ----------------------------------------------------------------------------
module nhit_window_trigger #(
  parameter int CHANNELS = nwt_pkg::CHANNELS_DEF,
  parameter int COLUMNS  = nwt_pkg::COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  channel,
  input  logic [47:0] hit_time,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [47:0] window_start,
  output logic [47:0] window_end,
  output logic [8:0]  hit_count,
  output logic [9:0]  trigger_column
);

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CUR_W   = $clog2(COLUMNS + 1);
  localparam int DIV_RAW = $clog2(nwt_pkg::BIN_NS * COLUMNS);
  localparam int NUM_W   = (DIV_RAW > 16) ? DIV_RAW : 16;
  localparam int SUM_W   = ((CUR_W > NUM_W) ? CUR_W : NUM_W) + 1;
  localparam int NSLICE  = (CHANNELS + nwt_pkg::SLICE - 1) / nwt_pkg::SLICE;
  localparam int SH_W    = NSLICE * nwt_pkg::SLICE;
  localparam int SL_W    = (NSLICE > 1) ? $clog2(NSLICE) : 1;
  localparam int CNT_W   = $clog2(CHANNELS + 1);
  localparam int K_W     = $clog2(nwt_pkg::SPREAD + 1);
  localparam int T_W     = nwt_pkg::TIME_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HDIV, S_HRD, S_HWR,
    S_WDIV, S_SCHK, S_SLOAD, S_SCNT, S_SCMP, S_SOUT
  } state_t;

  state_t state;

  // configuration
  logic [8:0]  hit_threshold;
  logic [15:0] window_ns;

  // persistent frame state
  logic [T_W-1:0]   frame_start;
  logic [CUR_W-1:0] cursor;

  // per item working registers
  logic [7:0]        ch_reg;
  logic [COL_W-1:0]  bin;
  logic [K_W-1:0]    k;
  logic [NUM_W-1:0]  step;
  logic [15:0]       q;
  logic [COL_W-1:0]  col;
  logic [SH_W-1:0]   shift;
  logic [SL_W-1:0]   sl_idx;
  logic [CNT_W-1:0]  cnt;
  logic [T_W-1:0]    center;
  logic [COL_W-1:0]  clr_addr;

  // shared divider
  logic                      div_go;
  logic [NUM_W-1:0]          div_num;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;
  logic [nwt_pkg::REM_W-1:0] div_rem;

  // table port
  logic                 mem_we;
  logic [COL_W-1:0]     mem_waddr;
  logic [CHANNELS-1:0]  mem_wdata;
  logic                 mem_re;
  logic [COL_W-1:0]     mem_raddr;
  logic [CHANNELS-1:0]  mem_rdata;
  logic [CHANNELS-1:0]  ch_mark;

  logic             accept;
  logic [T_W-1:0]   diff;
  logic             hit_ok;
  logic [T_W-1:0]   start_min;
  logic             cur_in_range;
  logic [COL_W-1:0] hit_addr;
  logic [SUM_W-1:0] cur_sum;
  logic [T_W-1:0]   col25;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // time offset from frame start wraps at 48 bits
  assign diff      = hit_time - frame_start;
  assign hit_ok    = (diff < T_W'(nwt_pkg::BIN_NS * COLUMNS)) && (32'(channel) < CHANNELS);
  assign start_min = (hit_time < frame_start) ? hit_time : frame_start;

  // only columns with spread room after them are searched
  assign cur_in_range = (32'(cursor) + nwt_pkg::SPREAD) < COLUMNS;
  assign hit_addr     = bin - COL_W'(k);
  assign cur_sum      = SUM_W'(col) + SUM_W'(step);
  assign col25        = (T_W'(col) << 4) + (T_W'(col) << 3) + T_W'(col);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_mark[i] = (32'(ch_reg) == i);
    end
  end

  assign div_go  = accept && ((opcode == nwt_pkg::OP_HIT && hit_ok) ||
                              opcode == nwt_pkg::OP_SEARCH);
  assign div_num = (opcode == nwt_pkg::OP_HIT) ? diff[NUM_W-1:0] : NUM_W'(window_ns);

  assign mem_re    = (state == S_HRD) || (state == S_SCHK && cur_in_range);
  assign mem_raddr = (state == S_HRD) ? hit_addr : cursor[COL_W-1:0];
  assign mem_we    = (state == S_HWR) || (state == S_CLEAR);
  assign mem_waddr = (state == S_HWR) ? hit_addr : clr_addr;
  assign mem_wdata = (state == S_HWR) ? (mem_rdata | ch_mark) : '0;

  nwt_div25 #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  nwt_mem #(
    .DEPTH (COLUMNS),
    .WIDTH (CHANNELS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold <= nwt_pkg::THRESHOLD_RST;
      window_ns     <= nwt_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nwt_pkg::REG_HIT_THRESHOLD: hit_threshold <= cfg_data[8:0];
        nwt_pkg::REG_WINDOW_NS:     window_ns     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      frame_start <= '1;
      cursor      <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_addr) == COLUMNS - 1) begin
            clr_addr <= '0;
            state    <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ch_reg         <= channel;
            status         <= nwt_pkg::ST_HIT_DROPPED;
            window_start   <= '0;
            window_end     <= '0;
            hit_count      <= '0;
            trigger_column <= '0;
            unique case (opcode)
              nwt_pkg::OP_START: begin
                frame_start  <= start_min;
                status       <= nwt_pkg::ST_START_TAKEN;
                window_start <= start_min;
                done         <= 1'b1;
              end
              nwt_pkg::OP_HIT: begin
                if (hit_ok) begin
                  state <= S_HDIV;
                end else begin
                  done <= 1'b1;
                end
              end
              nwt_pkg::OP_SEARCH: begin
                state <= S_WDIV;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_HDIV: begin
          if (div_done) begin
            bin   <= div_quot[COL_W-1:0];
            k     <= '0;
            state <= S_HRD;
          end
        end
        S_HRD: begin
          state <= S_HWR;
        end
        S_HWR: begin
          // mark bin, then up to spread earlier bins, never below bin 0
          if (32'(k) == nwt_pkg::SPREAD || COL_W'(k) == bin) begin
            status         <= nwt_pkg::ST_HIT_STORED;
            trigger_column <= 10'(bin);
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_HRD;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            step  <= (div_quot == '0) ? NUM_W'(1) : div_quot;
            q     <= window_ns - 16'(div_rem);
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (cur_in_range) begin
            col   <= cursor[COL_W-1:0];
            state <= S_SLOAD;
          end else begin
            // table used up: report, restart the frame and sweep the table
            status      <= nwt_pkg::ST_SEARCH_DONE;
            done        <= 1'b1;
            frame_start <= '1;
            cursor      <= '0;
            clr_addr    <= '0;
            state       <= S_CLEAR;
          end
        end
        S_SLOAD: begin
          shift  <= SH_W'(mem_rdata);
          sl_idx <= '0;
          cnt    <= '0;
          state  <= S_SCNT;
        end
        S_SCNT: begin
          cnt    <= cnt + CNT_W'(nwt_pkg::popcount(shift[nwt_pkg::SLICE-1:0]));
          shift  <= shift >> nwt_pkg::SLICE;
          sl_idx <= sl_idx + 1'b1;
          if (32'(sl_idx) == NSLICE - 1) begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (32'(cnt) >= 32'(hit_threshold)) begin
            center <= frame_start + col25;
            cursor <= (cur_sum > SUM_W'(COLUMNS)) ? CUR_W'(COLUMNS) : CUR_W'(cur_sum);
            state  <= S_SOUT;
          end else begin
            cursor <= cursor + 1'b1;
            state  <= S_SCHK;
          end
        end
        S_SOUT: begin
          status         <= nwt_pkg::ST_WINDOW;
          window_start   <= center - T_W'(q);
          window_end     <= center + T_W'(q);
          hit_count      <= 9'(cnt);
          trigger_column <= 10'(col);
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) <= COLUMNS)
    else $error("search cursor past table end");

  a_div_from_idle: assert property (@(posedge clk) disable iff (rst)
    div_go |-> state == S_IDLE)
    else $error("divider started while busy");

  a_spread_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_HWR |-> COL_W'(k) <= bin)
    else $error("hit marked below bin zero");

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && $past(state == S_CLEAR)) |-> !done)
    else $error("result during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= nwt_pkg::ST_START_TAKEN)
    else $error("bad result status");
`endif

endmodule

>>> rtl/core/nwt_div25.sv
// ----------------------------------------------------------------------------
// nwt_div25: reciprocal divider by the bin width
// one registered multiply by a scaled reciprocal, gives quotient and remainder
// ----------------------------------------------------------------------------
module nwt_div25 #(
  parameter int NUM_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [NUM_W-1:0]         num,
  output logic                     done,
  output logic [NUM_W-1:0]         quot,
  output logic [nwt_pkg::REM_W-1:0] rem
);

  // scale leaves the rounding error below 1/32, so the floor is exact
  localparam int     SH    = NUM_W + 5;
  localparam int     RCP_W = NUM_W + 1;
  localparam int     PRD_W = NUM_W + RCP_W;
  localparam longint RECIP = ((longint'(1) << SH) + nwt_pkg::BIN_NS - 1) / nwt_pkg::BIN_NS;

  logic [NUM_W-1:0] num_r;
  logic [PRD_W-1:0] prod;
  logic [NUM_W-1:0] q25;

  assign quot = NUM_W'(prod >> SH);
  assign q25  = (quot << 4) + (quot << 3) + quot;
  assign rem  = nwt_pkg::REM_W'(num_r - q25);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
      if (go) begin
        num_r <= num;
        prod  <= PRD_W'(num) * PRD_W'(RECIP);
      end
    end
  end

endmodule

>>> rtl/core/nwt_mem.sv
// ----------------------------------------------------------------------------
// nwt_mem: bin table storage
// one row per column, one write port and one registered read port
// ----------------------------------------------------------------------------
module nwt_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
